@@ src/rkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// rkvc_pkg - shared types and constants of the rotating-key byte cipher
// Request codes, key storage shape and the interface between top and core.
// ----------------------------------------------------------------------------
package rkvc_pkg;

  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KEY_SLOTS   = 32;  // key bytes held in the key words
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned ROT_W       = 3;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [1:0] {
    REQ_ENCODE  = 2'd0,
    REQ_DECODE  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // Snapshot of one cipher request as held in the input stage
  typedef struct packed {
    logic              decode;
    logic [SLOT_W-1:0] slot;
    logic [ROT_W-1:0]  rot;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

@@ src/rkvc_core.sv @@
// ----------------------------------------------------------------------------
// rkvc_core - cipher datapath
// Selects the key byte, rotates it by the pass count and adds or subtracts
// it together with key byte 0.
// ----------------------------------------------------------------------------
module rkvc_core (
  input  rkvc_pkg::key_t                 key,
  input  rkvc_pkg::op_t                  op,
  output logic [rkvc_pkg::BYTE_W-1:0]    result
);

  logic [rkvc_pkg::KEY_SLOTS-1:0][rkvc_pkg::BYTE_W-1:0] key_bytes;
  logic [rkvc_pkg::BYTE_W-1:0]   sel_byte;
  logic [2*rkvc_pkg::BYTE_W-1:0] rot_wide;
  logic [rkvc_pkg::BYTE_W-1:0]   rot_byte;
  logic [rkvc_pkg::BYTE_W-1:0]   sum;

  assign key_bytes = key;  // little-endian: byte 0 is the low byte of word 0
  assign sel_byte  = key_bytes[op.slot];
  assign rot_wide  = {sel_byte, sel_byte} << op.rot;
  assign rot_byte  = rot_wide[2*rkvc_pkg::BYTE_W-1:rkvc_pkg::BYTE_W];
  assign sum       = key_bytes[0] + rot_byte;
  assign result    = op.decode ? (op.data - sum) : (op.data + sum);

endmodule

@@ src/rotating_key_vigenere_byte_cipher_top.sv @@
// ----------------------------------------------------------------------------
// rotating_key_vigenere_byte_cipher_top - rotating-key byte cipher
// Path: an accepted request is held in the input register, then its result in the result register on m_tdata.
// Throughput: one request per cycle, set by the input and result registers
//   moving together whenever the result register is free or being drained.
// Restart and unused requests give no result.
// Reset (rst, synchronous): clears key words, key position, pass count, valids.
// ----------------------------------------------------------------------------
module rotating_key_vigenere_byte_cipher_top #(
  parameter int unsigned KEY_BYTES = 32  // stream period in key bytes, 8 to 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input requests
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] data_byte
  input  logic [1:0]                           s_tuser,   // [1:0] req_type
  // results
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,   // [7:0] result_byte
  // key register writes
  input  logic                                 cfg_wen,
  input  logic [rkvc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rkvc_pkg::WORD_W-1:0]          cfg_wdata
);

  localparam int unsigned POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(KEY_BYTES - 1);

  // Key words, read live by the datapath
  rkvc_pkg::key_t key;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wen) begin
      key[cfg_index] <= cfg_wdata;
    end
  end

  // Keystream state
  logic [POS_W-1:0]          key_position, key_position_next;
  logic [rkvc_pkg::ROT_W-1:0] pass_rotation, pass_rotation_next;
  logic [POS_W-1:0]          pos_eff;
  rkvc_pkg::req_t            req;
  logic                      in_acc, is_op;

  // Pipeline control
  logic          s1_valid;
  rkvc_pkg::op_t s1_op;
  logic          out_load;

  assign req      = rkvc_pkg::req_t'(s_tuser);
  assign out_load = !m_tvalid || m_tready;          // result register free or draining
  assign s_tready = !s1_valid || out_load;
  assign in_acc   = s_tvalid && s_tready;
  assign is_op    = (req == rkvc_pkg::REQ_ENCODE) || (req == rkvc_pkg::REQ_DECODE);

  // out-of-range position counts as zero
  assign pos_eff = ({1'b0, key_position} >= (POS_W+1)'(KEY_BYTES)) ? '0 : key_position;

  always_comb begin
    key_position_next  = key_position;
    pass_rotation_next = pass_rotation;
    if (in_acc) begin
      unique case (req)
        rkvc_pkg::REQ_ENCODE, rkvc_pkg::REQ_DECODE: begin
          if (pos_eff == LAST_POS) begin
            key_position_next  = '0;
            pass_rotation_next = pass_rotation + 1'b1;
          end else begin
            key_position_next = pos_eff + 1'b1;
          end
        end
        rkvc_pkg::REQ_RESTART: begin
          key_position_next  = '0;
          pass_rotation_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position  <= '0;
      pass_rotation <= '0;
    end else begin
      key_position  <= key_position_next;
      pass_rotation <= pass_rotation_next;
    end
  end

  // Input stage: snapshot of the request and its keystream slot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= in_acc && is_op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op.decode <= (req == rkvc_pkg::REQ_DECODE);
      s1_op.slot   <= rkvc_pkg::SLOT_W'(pos_eff);
      s1_op.rot    <= pass_rotation;
      s1_op.data   <= s_tdata;
    end
  end

  // Datapath between input and result registers
  logic [rkvc_pkg::BYTE_W-1:0] core_result;

  rkvc_core u_core (
    .key    (key),
    .op     (s1_op),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      m_tdata <= core_result;
    end
  end

`ifndef SYNTHESIS
  // restart leaves the keystream at its start
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && (req == rkvc_pkg::REQ_RESTART) |=> (key_position == '0) && (pass_rotation == '0))
    else $error("restart did not clear keystream state");

  // every accepted cipher request lands in the input stage
  a_op_captured: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_op |=> s1_valid)
    else $error("accepted cipher request lost");

  // pass count steps and the position returns to zero when the position wraps
  a_pass_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_op && (pos_eff == LAST_POS)
    |=> (pass_rotation == $past(pass_rotation) + 1'b1) && (key_position == '0))
    else $error("pass count did not advance at wrap");

  // position stays inside the key
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, key_position} < (POS_W+1)'(KEY_BYTES))
    else $error("key position out of range");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - regression for the rotating-key byte cipher
// Directed requests at the field extremes, then randomised request streams
// over a series of key settings. Each result is checked against the local
// keystream model or a typed-in byte, with random stalls on both stream interfaces.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY     = 1;             // request edge to result edge
  localparam int DRAIN       = LATENCY + 4;   // settle time before key writes
  localparam int IDLE_PCT    = 18;            // chance of a bubble per cycle
  localparam int HOLD_CYCLES = 80;            // long back-pressure stretch
  localparam int PHASES      = 8;
  localparam int TIMEOUT     = 3_000_000;     // time units, far beyond a slow run

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = '0;       // [7:0] data_byte
  logic [1:0]                       s_tuser = rkvc_pkg::REQ_ENCODE;  // [1:0] req_type
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [7:0]                       m_tdata;            // [7:0] result_byte
  logic                             cfg_wen = 1'b0;
  logic [rkvc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rkvc_pkg::WORD_W-1:0]      cfg_wdata = '0;

  rotating_key_vigenere_byte_cipher_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // Keystream model: shadow key words plus position and pass count
  // -------------------------------------------------------------------------
  rkvc_pkg::key_t              key_shadow = '0;
  logic [rkvc_pkg::SLOT_W-1:0] stream_pos = '0;
  logic [rkvc_pkg::ROT_W-1:0]  pass_count = '0;

  logic [7:0] cipher_bytes_due[$];   // results still owed by the block
  int errors        = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int restarts_sent = 0;
  int unused_sent   = 0;
  int key_settings  = 0;

  bit steady       = 1'b0;  // no bubbles and no stalls on either side
  bit hold_request = 1'b0;  // ask the result side for a long hold-off

  // Returns 1 with the cipher byte when the request produces one.
  function automatic bit vigenere_step(input rkvc_pkg::req_t req, input logic [7:0] data,
                                       output logic [7:0] res);
    logic [7:0]  key_lead;
    logic [7:0]  key_byte;
    logic [15:0] doubled;
    logic [7:0]  offset;
    res = '0;
    if (req == rkvc_pkg::REQ_RESTART) begin
      stream_pos = '0;
      pass_count = '0;
      return 1'b0;
    end
    if (req == rkvc_pkg::REQ_UNUSED)
      return 1'b0;
    if (stream_pos >= rkvc_pkg::KEY_SLOTS)
      stream_pos = '0;
    key_lead = key_shadow[0][7:0];
    key_byte = key_shadow[stream_pos[4:3]][stream_pos[2:0]*rkvc_pkg::BYTE_W +: rkvc_pkg::BYTE_W];
    // rotate left through a doubled copy
    doubled  = {key_byte, key_byte} << pass_count;
    offset   = key_lead + doubled[15:8];
    res      = (req == rkvc_pkg::REQ_ENCODE) ? data + offset : data - offset;
    if (stream_pos == rkvc_pkg::KEY_SLOTS - 1) begin
      stream_pos = '0;
      pass_count = pass_count + 1'b1;
    end else begin
      stream_pos = stream_pos + 1'b1;
    end
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Request side
  // -------------------------------------------------------------------------
  // Offers one request, waits for the handshake, then logs any expected byte.
  // A typed-in byte replaces the model's where the answer is obvious.
  task automatic send_request(input rkvc_pkg::req_t req, input logic [7:0] data,
                              input bit typed, input logic [7:0] typed_byte);
    logic [7:0] res;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (req == rkvc_pkg::REQ_RESTART) restarts_sent++;
    if (req == rkvc_pkg::REQ_UNUSED)  unused_sent++;
    if (vigenere_step(req, data, res))
      cipher_bytes_due.push_back(typed ? typed_byte : res);
  endtask

  // Stops offering and lets every owed result come back, plus some slack.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cipher_bytes_due.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Writes the key words picked by mask, back to back; only while idle.
  task automatic write_keys(input rkvc_pkg::key_t words,
                            input logic [rkvc_pkg::KEY_WORDS-1:0] mask);
    for (int w = 0; w < rkvc_pkg::KEY_WORDS; w++) begin
      if (mask[w]) begin
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= rkvc_pkg::CFG_INDEX_W'(w);
        cfg_wdata <= words[w];
        key_shadow[w] = words[w];
      end
    end
    @(negedge clk);
    cfg_wen <= 1'b0;
    key_settings++;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls, a long hold-off on request, none when steady
  // -------------------------------------------------------------------------
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  logic [7:0] due_byte;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: expected none, got %02h",
                 $time, m_tdata);
      end else begin
        due_byte = cipher_bytes_due.pop_front();
        results_seen++;
        if (m_tdata !== due_byte) begin
          errors++;
          $display("%0t: result_byte mismatch: expected %02h, got %02h",
                   $time, due_byte, m_tdata);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Directed table
  // -------------------------------------------------------------------------
  typedef struct {
    bit             load_key;   // idle, then fill all four key words first
    logic [63:0]    key_fill;
    rkvc_pkg::req_t req;
    logic [7:0]     data;
    bit             typed;      // typed-in result rather than the model's
    logic [7:0]     typed_byte;
  } stim_row_t;

  stim_row_t directed_rows[$];

  task automatic add_row(input bit load_key, input logic [63:0] key_fill,
                         input rkvc_pkg::req_t req, input logic [7:0] data,
                         input bit typed, input logic [7:0] typed_byte);
    stim_row_t r;
    r.load_key   = load_key;
    r.key_fill   = key_fill;
    r.req        = req;
    r.data       = data;
    r.typed      = typed;
    r.typed_byte = typed_byte;
    directed_rows.push_back(r);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rkvc_pkg::key_t                 words;
    logic [rkvc_pkg::KEY_WORDS-1:0] mask;
    int                             count;
    int                             restart_pct;
    int                             pick;
    rkvc_pkg::req_t                 req;

    // zero key out of reset: bytes pass straight through
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'h00, 1'b1, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'hFF, 1'b1, 8'hFF);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'h00, 1'b1, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'hFF, 1'b1, 8'hFF);
    add_row(1'b0, '0, rkvc_pkg::REQ_UNUSED,  8'hA5, 1'b0, 8'h00);  // ignored code
    add_row(1'b0, '0, rkvc_pkg::REQ_RESTART, 8'h5A, 1'b0, 8'h00);  // no result
    // all-ones key: every rotation is FF, offset FE whatever the position
    add_row(1'b1, '1, rkvc_pkg::REQ_ENCODE,  8'h00, 1'b1, 8'hFE);
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'hFF, 1'b1, 8'hFD);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'h00, 1'b1, 8'h02);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'hFF, 1'b1, 8'h01);
    // eight distinct key bytes repeated in every word, restarted stream
    add_row(1'b1, 64'h0123_4567_89AB_CDEF, rkvc_pkg::REQ_RESTART, 8'hFF, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'h3C, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'hC3, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_UNUSED,  8'h00, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'h80, 1'b0, 8'h00);
    // key rewritten mid-stream: position and pass count carry on
    add_row(1'b1, 64'hFEDC_BA98_7654_3210, rkvc_pkg::REQ_ENCODE, 8'h11, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_DECODE,  8'h22, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_RESTART, 8'h00, 1'b0, 8'h00);
    add_row(1'b0, '0, rkvc_pkg::REQ_ENCODE,  8'h33, 1'b0, 8'h00);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_key) begin
        wait_idle();
        write_keys({rkvc_pkg::KEY_WORDS{directed_rows[i].key_fill}}, '1);
      end
      send_request(directed_rows[i].req, directed_rows[i].data,
                   directed_rows[i].typed, directed_rows[i].typed_byte);
    end

    // Random phases. Phase 2 is one long stream without restarts so the
    // pass count wraps at least once; phase 3 runs with no stalls at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      steady = (phase == 3);
      mask   = '1;
      for (int w = 0; w < rkvc_pkg::KEY_WORDS; w++)
        words[w] = {$urandom(), $urandom()};
      case (phase)
        1: words = '1;
        3: words = {rkvc_pkg::KEY_WORDS{64'hAA55_AA55_55AA_55AA}};
        4: begin
          // only the word holding the leading key byte changes
          words[3:1] = key_shadow[3:1];
          mask       = 4'b0001;
        end
        5: words = '0;
        6: words[0][7:0] = 8'hFF;
        default: ;
      endcase
      write_keys(words, mask);

      count       = (phase == 2) ? 520 : 130;
      restart_pct = (phase == 2) ? 0 : (phase == 6) ? 10 : 2;
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(99);
        if (pick < restart_pct)
          req = rkvc_pkg::REQ_RESTART;
        else if (pick < restart_pct + 3)
          req = rkvc_pkg::REQ_UNUSED;
        else
          req = ($urandom_range(1) == 0) ? rkvc_pkg::REQ_ENCODE : rkvc_pkg::REQ_DECODE;
        send_request(req, 8'($urandom_range(255)), 1'b0, 8'h00);
        // back-pressure while requests keep coming, so the input stalls
        if (phase == 2 && i == 100)
          hold_request = 1'b1;
      end
    end

    wait_idle();
    $display("covered %0d requests (%0d restarts, %0d unused codes) over %0d key settings,",
             requests_sent, restarts_sent, unused_sent, key_settings);
    $display("with %0d cipher bytes checked and %0d errors", results_seen, errors);
    if (errors == 0)
      $display("rotating_key_vigenere_byte_cipher_top regression: pass");
    else
      $display("rotating_key_vigenere_byte_cipher_top regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT);
    $display("timeout at %0t with %0d results outstanding", $time,
             cipher_bytes_due.size());
    $display("rotating_key_vigenere_byte_cipher_top regression: fail");
    $finish;
  end

endmodule
